// File: rtl/dist_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the disk idle standby timer.
// Used by dist_step and disk_idle_standby_timer; depends on nothing.
package dist_pkg;

    localparam int unsigned CountW = 32;
    localparam int unsigned SecW   = 16;
    localparam int unsigned IdxW   = 1;

    localparam logic [SecW-1:0] IdleLimitReset = 16'd20;
    localparam logic [SecW-1:0] MinGuardReset  = 16'd0;

    localparam logic [IdxW-1:0] RegIdleLimit = 1'd0;
    localparam logic [IdxW-1:0] RegMinGuard  = 1'd1;

    localparam logic [1:0] KindTick    = 2'd0;
    localparam logic [1:0] KindResume  = 2'd1;
    localparam logic [1:0] KindStandby = 2'd2;

    localparam logic [1:0] DriveOn      = 2'd0;
    localparam logic [1:0] DriveStandby = 2'd1;

    localparam logic [1:0] CmdNone    = 2'd0;
    localparam logic [1:0] CmdResume  = 2'd1;
    localparam logic [1:0] CmdSuspend = 2'd2;

    localparam logic StatusOk      = 1'b0;
    localparam logic StatusRefused = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CountW-1:0] activity_count;
        logic [1:0]        drive_state;
        logic              suspend_refused;
    } item_t;

    typedef struct packed {
        logic            status;
        logic [1:0]      command;
        logic [SecW-1:0] seconds_left;
    } result_t;

    typedef struct packed {
        logic [SecW-1:0] idle_limit;
        logic [SecW-1:0] min_guard;
    } cfg_t;

    function automatic logic [SecW-1:0] eff_limit(input cfg_t c);
        return (c.idle_limit > c.min_guard) ? c.idle_limit : c.min_guard;
    endfunction

endpackage

// File: rtl/disk_idle_standby_timer.sv
`timescale 1ns / 1ps
// Top level of the disk idle standby timer: stream ports, config registers,
// input and result registers. Depends on dist_pkg and dist_step.
//
// One request enters per clock while s_tready is high. It is held in the request
// register, evaluated combinationally, and registered into the result register,
// which drives m_tvalid. The request register and the result register hold
// one request each, so s_tready drops only when both are full and m_tready is
// low. The countdown and the last I/O count update in the single evaluation
// pass between the two registers, so every request sees the state that the
// previous one left. Config writes are taken on any cycle and should be made
// only while idle.
module disk_idle_standby_timer
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,  // activity_count, drive_state, suspend_refused, pad
    input  logic [1:0]                 s_tuser,  // kind
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,  // status, command, seconds_left, pad
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dist_pkg::IdxW-1:0]  cfg_index,
    input  logic [dist_pkg::SecW-1:0]  cfg_data
);
    import dist_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_vld_reg;
    logic    out_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {5'd0, res_reg.seconds_left, res_reg.command, res_reg.status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_limit <= IdleLimitReset;
            cfg_reg.min_guard  <= MinGuardReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                RegIdleLimit: cfg_reg.idle_limit <= cfg_data;
                RegMinGuard:  cfg_reg.min_guard  <= cfg_data;
                default:      cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // hold the request until it passes to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind            <= s_tuser;
            item_reg.activity_count  <= s_tdata[31:0];
            item_reg.drive_state     <= s_tdata[33:32];
            item_reg.suspend_refused <= s_tdata[34];
        end
    end

    dist_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: rtl/dist_step.sv
`timescale 1ns / 1ps
// Countdown state and single-pass evaluation of one request.
// Depends on dist_pkg.
module dist_step
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  dist_pkg::cfg_t   cfg,
    input  dist_pkg::item_t  item,
    output dist_pkg::result_t result
);
    import dist_pkg::*;

    logic [SecW-1:0]   idle_left_reg;
    logic [SecW-1:0]   idle_left_next;
    logic [CountW-1:0] last_activity_reg;
    logic [CountW-1:0] last_activity_next;

    logic [SecW-1:0] eff;
    logic [SecW-1:0] gap;
    logic [SecW-1:0] cur_left;
    logic            busy;
    logic            do_eval;
    logic            status;
    logic [1:0]      command;

    always_comb
    begin
        eff                = eff_limit(cfg);
        gap                = eff - cfg.min_guard;
        busy               = (item.drive_state != DriveOn) && (item.drive_state != DriveStandby);
        cur_left           = idle_left_reg;
        do_eval            = 1'b0;
        status             = StatusOk;
        command            = CmdNone;
        last_activity_next = last_activity_reg;

        unique case (item.kind)
            KindTick:
            begin
                do_eval = 1'b1;
            end
            KindResume:
            begin
                if (busy)
                begin
                    status = StatusRefused;
                end
                else if (item.drive_state == DriveStandby)
                begin
                    cur_left = eff;
                    command  = CmdResume;
                end
            end
            KindStandby:
            begin
                if (busy)
                begin
                    status = StatusRefused;
                end
                else if (item.drive_state == DriveOn)
                begin
                    cur_left = (idle_left_reg >= gap) ? (idle_left_reg - gap) : '0;
                    do_eval  = 1'b1;
                end
            end
            default:
            begin
                do_eval = 1'b0;
            end
        endcase

        idle_left_next = cur_left;
        if (do_eval && (eff != '0))
        begin
            if ((item.activity_count == '0) || (item.activity_count != last_activity_reg))
            begin
                last_activity_next = item.activity_count;
                idle_left_next     = eff;
            end
            else if (item.drive_state == DriveOn)
            begin
                if (cur_left == '0)
                begin
                    command        = CmdSuspend;
                    idle_left_next = item.suspend_refused ? '0 : eff;
                end
                else
                begin
                    idle_left_next = cur_left - SecW'(1);
                end
            end
        end

        result.status       = status;
        result.command      = command;
        result.seconds_left = idle_left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_left_reg     <= IdleLimitReset;
            last_activity_reg <= '0;
        end
        else if (advance)
        begin
            idle_left_reg     <= idle_left_next;
            last_activity_reg <= last_activity_next;
        end
    end

endmodule

// File: rtl/dist_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the disk idle standby timer, bound to the top level.
// Depends on disk_idle_standby_timer.
module dist_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty result register");

    ap_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:1] != 2'd3)
        else $error("undefined command");

    ap_refused: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == 2'd0)
        else $error("refused request issued a command");

endmodule

bind disk_idle_standby_timer dist_checker u_dist_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for disk_idle_standby_timer: directed and random requests with a
// scoreboard that predicts status, command and countdown for every request.
// Depends on dist_pkg and the disk_idle_standby_timer RTL only.

import dist_pkg::*;

class timer_scoreboard;
    logic [SecW-1:0]   idle_limit;
    logic [SecW-1:0]   min_guard;
    logic [SecW-1:0]   idle_left;
    logic [CountW-1:0] last_activity;
    result_t           due_q[$];
    int                errors;

    function new();
        idle_limit    = IdleLimitReset;
        min_guard     = MinGuardReset;
        idle_left     = limit_now();
        last_activity = '0;
        errors        = 0;
    endfunction

    function logic [SecW-1:0] limit_now();
        return (idle_limit > min_guard) ? idle_limit : min_guard;
    endfunction

    function void write_reg(logic [IdxW-1:0] index, logic [SecW-1:0] data);
        if (index == RegIdleLimit)
            idle_limit = data;
        else if (index == RegMinGuard)
            min_guard = data;
    endfunction

    function logic [1:0] count_down(logic [CountW-1:0] count, logic [1:0] dstate,
                                    logic refused);
        logic [SecW-1:0] lim;
        lim = limit_now();
        if (lim == '0)
            return CmdNone;
        if (count == '0 || count != last_activity)
        begin
            last_activity = count;
            idle_left     = lim;
            return CmdNone;
        end
        if (dstate != DriveOn)
            return CmdNone;
        if (idle_left == '0)
        begin
            if (!refused)
                idle_left = lim;
            return CmdSuspend;
        end
        idle_left = idle_left - 16'd1;
        return CmdNone;
    endfunction

    function void note_request(item_t req);
        result_t r;
        logic    busy;
        int      remain;
        r.status  = StatusOk;
        r.command = CmdNone;
        busy = (req.drive_state != DriveOn) && (req.drive_state != DriveStandby);
        case (req.kind)
            KindTick:
                r.command = count_down(req.activity_count, req.drive_state,
                                       req.suspend_refused);
            KindResume:
                if (busy)
                    r.status = StatusRefused;
                else if (req.drive_state == DriveStandby)
                begin
                    idle_left = limit_now();
                    r.command = CmdResume;
                end
            KindStandby:
                if (busy)
                    r.status = StatusRefused;
                else if (req.drive_state == DriveOn)
                begin
                    remain = int'(min_guard) - int'(limit_now()) + int'(idle_left);
                    idle_left = (remain < 0) ? '0 : remain[SecW-1:0];
                    r.command = count_down(req.activity_count, req.drive_state,
                                           req.suspend_refused);
                end
            default:
                ;
        endcase
        r.seconds_left = idle_left;
        due_q.push_back(r);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (due_q.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d command=%0d seconds_left=%0d",
                     $time, got.status, got.command, got.seconds_left);
            errors++;
            return;
        end
        want = due_q.pop_front();
        if (got.status !== want.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.command !== want.command)
        begin
            $display("%0t: command expected %0d actual %0d", $time, want.command,
                     got.command);
            errors++;
        end
        if (got.seconds_left !== want.seconds_left)
        begin
            $display("%0t: seconds_left expected %0d actual %0d", $time,
                     want.seconds_left, got.seconds_left);
            errors++;
        end
    endfunction

    function int pending();
        return due_q.size();
    endfunction
endclass

module tb_top;

    localparam logic [1:0] KindUnknown  = 2'd3;
    localparam logic [1:0] DriveBusy    = 2'd2;
    localparam logic [1:0] DriveUnknown = 2'd3;
    localparam int         NumPhases    = 12;
    localparam int         PhaseItems   = 128;
    localparam int         HoldCycles   = 300;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IdxW-1:0]   cfg_index;
    logic [SecW-1:0]   cfg_data;

    timer_scoreboard   sb;
    logic [CountW-1:0] last_count;
    int                burst_left;
    int                hold_asked;
    logic [SecW-1:0]   phase_limit [NumPhases];
    logic [SecW-1:0]   phase_guard [NumPhases];

    disk_idle_standby_timer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        item_t   req;
        result_t res;
        if (rst_n && s_tvalid && s_tready)
        begin
            req.kind            = s_tuser;
            req.activity_count  = s_tdata[31:0];
            req.drive_state     = s_tdata[33:32];
            req.suspend_refused = s_tdata[34];
            sb.note_request(req);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            res.status       = m_tdata[0];
            res.command      = m_tdata[2:1];
            res.seconds_left = m_tdata[18:3];
            sb.check_result(res);
        end
    end

    initial
    begin
        int unsigned rx_cycle;
        int          hold_served;
        int          hold_left;
        rx_cycle    = 0;
        hold_served = 0;
        hold_left   = 0;
        m_tready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 97) % 3)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((rx_cycle % 7) < 4);
                endcase
            end
            rx_cycle++;
        end
    end

    initial
    begin
        #1_600_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic item_t make_request(logic [1:0] kind, logic [CountW-1:0] count,
                                           logic [1:0] dstate, logic refused);
        item_t r;
        r.kind            = kind;
        r.activity_count  = count;
        r.drive_state     = dstate;
        r.suspend_refused = refused;
        return r;
    endfunction

    function automatic item_t random_request();
        int unsigned pick;
        logic [1:0]  kind;
        logic [1:0]  dstate;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            last_count = last_count;
        else if (pick < 90)
            last_count = last_count + 32'd1;
        else if (pick < 96)
            last_count = $urandom;
        else
            last_count = '0;
        pick = $urandom_range(0, 99);
        kind = (pick < 78) ? KindTick : (pick < 86) ? KindResume :
               (pick < 96) ? KindStandby : KindUnknown;
        pick = $urandom_range(0, 99);
        dstate = (pick < 80) ? DriveOn : (pick < 90) ? DriveStandby :
                 (pick < 96) ? DriveBusy : DriveUnknown;
        return make_request(kind, last_count, dstate, ($urandom_range(0, 9) < 3));
    endfunction

    task automatic send(input item_t req);
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {5'd0, req.suspend_refused, req.drive_state, req.activity_count};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles)
                @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [SecW-1:0] lim, input logic [SecW-1:0] guard);
        cfg_valid <= 1'b1;
        cfg_index <= RegIdleLimit;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(RegIdleLimit, lim);
        @(negedge clk);
        cfg_index <= RegMinGuard;
        cfg_data  <= guard;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(RegMinGuard, guard);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit gaps_on);
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                if (gaps_on)
                    pause($urandom_range(0, 5));
                burst_left = $urandom_range(1, 16);
            end
            send(random_request());
            burst_left--;
        end
    endtask

    initial
    begin
        sb          = new();
        last_count  = '0;
        burst_left  = 0;
        hold_asked  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KindTick;
        cfg_valid   = 1'b0;
        cfg_index   = RegIdleLimit;
        cfg_data    = '0;
        phase_limit = '{16'd0, 16'd3, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF,
                        16'd2, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0};
        phase_guard = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0,
                        16'd0, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0};
        for (int p = 8; p < 11; p++)
        begin
            phase_limit[p] = SecW'($urandom_range(0, 8));
            phase_guard[p] = SecW'($urandom_range(0, 5));
        end
        phase_limit[11] = SecW'($urandom_range(0, 65535));
        phase_guard[11] = SecW'($urandom_range(0, 65535));

        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(make_request(KindTick, 32'd5, DriveOn, 1'b0));
        send(make_request(KindTick, 32'd5, DriveOn, 1'b0));
        send(make_request(KindStandby, 32'd5, DriveOn, 1'b0));
        send(make_request(KindStandby, 32'd5, DriveOn, 1'b1));
        send(make_request(KindTick, 32'd5, DriveOn, 1'b1));
        send(make_request(KindTick, 32'd5, DriveOn, 1'b0));
        send(make_request(KindResume, 32'd5, DriveStandby, 1'b0));
        send(make_request(KindResume, 32'd5, DriveOn, 1'b0));
        send(make_request(KindStandby, 32'd5, DriveStandby, 1'b0));
        send(make_request(KindResume, 32'd5, DriveBusy, 1'b0));
        send(make_request(KindStandby, 32'd5, DriveUnknown, 1'b1));
        send(make_request(KindUnknown, 32'd5, DriveOn, 1'b1));
        send(make_request(KindTick, 32'd5, DriveBusy, 1'b0));
        send(make_request(KindTick, 32'd6, DriveBusy, 1'b0));
        send(make_request(KindTick, 32'd6, DriveStandby, 1'b0));
        send(make_request(KindTick, 32'd0, DriveOn, 1'b0));
        send(make_request(KindTick, 32'd0, DriveOn, 1'b0));
        send(make_request(KindTick, 32'hFFFF_FFFF, DriveOn, 1'b1));
        send(make_request(KindTick, 32'hFFFF_FFFF, DriveOn, 1'b1));
        send(make_request(KindTick, 32'hAAAA_AAAA, DriveUnknown, 1'b1));
        send(make_request(KindTick, 32'h5555_5555, DriveOn, 1'b0));
        send(make_request(KindUnknown, 32'd0, DriveUnknown, 1'b0));
        last_count = 32'h5555_5555;

        for (int p = 0; p < NumPhases; p++)
        begin
            drain();
            write_cfg(phase_limit[p], phase_guard[p]);
            if (p == 1 || p == 7)
                hold_asked++;
            run_random(PhaseItems, (p % 3) != 0);
        end

        drain();
        repeat (8)
            @(negedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
